/* hdl/slrp_pkg.sv */
`default_nettype none

package slrp_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_E         = 8'h45;
   localparam logic [7:0] CHAR_O         = 8'h4F;
   localparam logic [7:0] CHAR_T         = 8'h54;

   // Window byte that must hold the separator when a record is judged.
   localparam int SEP_POS = 6;

   localparam logic [8:0] LIMIT_MAX   = 9'd256;
   localparam logic [8:0] LIMIT_RESET = 9'd256;

   localparam logic [3:0] OFFSET_JUDGE = 4'd8;
   localparam logic [3:0] OFFSET_CARRY = 4'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_SEEK  = 2'd0,
      PH_FIRST = 2'd1,
      PH_NEXT  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STOP_DATA  = 2'd0,
      STOP_EOT   = 2'd1,
      STOP_SEP   = 2'd2,
      STOP_LIMIT = 2'd3
   } stop_type;

   typedef enum logic {
      KIND_RECORD  = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] ip_address;
      logic [15:0] port_number;
      logic [7:0]  record_index;
      logic [8:0]  record_count;
      stop_type    stop_reason;
      logic        last;
   } result_type;

   // Results caused by one accepted byte; the record always goes out first.
   typedef struct packed {
      logic       rec_valid;
      logic       sum_valid;
      result_type rec;
      result_type sum;
   } result_pair_type;

endpackage

`default_nettype wire

/* hdl/slrp_parse.sv */
`default_nettype none

module slrp_parse (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  wire  [7:0]              data_byte,
   input  wire                     packet_end,
   input  wire                     csr_write,
   input  wire  [8:0]              csr_data,
   output slrp_pkg::result_pair_type pair
);

   slrp_pkg::phase_type phase_ff, phase_in;
   slrp_pkg::stop_type  cause_ff, cause_in;
   logic [3:0]          offset_ff, offset_in;
   logic [8:0]          count_ff, count_in;
   logic [8:0]          max_records_ff;
   logic [7:0]          win_ff [8];
   logic [7:0]          win_in [8];
   logic [8:0]          limit;
   logic [8:0]          count_plus;
   logic                is_eot;

   always_comb begin
      if (max_records_ff == 9'd0) begin
         limit = 9'd1;
      end else if (max_records_ff > slrp_pkg::LIMIT_MAX) begin
         limit = slrp_pkg::LIMIT_MAX;
      end else begin
         limit = max_records_ff;
      end
   end

   assign count_plus = count_ff + 9'd1;
   assign is_eot = (phase_ff == slrp_pkg::PH_NEXT) && (offset_ff == slrp_pkg::OFFSET_CARRY) &&
                   (win_ff[0] == slrp_pkg::CHAR_E) && (win_ff[1] == slrp_pkg::CHAR_O) &&
                   (data_byte == slrp_pkg::CHAR_T);

   always_comb begin
      phase_in  = phase_ff;
      cause_in  = cause_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      win_in    = win_ff;
      pair      = '0;

      pair.rec.kind         = slrp_pkg::KIND_RECORD;
      pair.rec.ip_address   = {win_ff[0], win_ff[1], win_ff[2], win_ff[3]};
      pair.rec.port_number  = {win_ff[4], win_ff[5]};
      pair.rec.record_index = count_ff[7:0];
      pair.rec.record_count = 9'd0;
      pair.rec.stop_reason  = slrp_pkg::STOP_DATA;
      pair.rec.last         = !packet_end;

      if (accept) begin
         unique case (phase_ff) inside
            slrp_pkg::PH_SEEK: begin
               if (data_byte == slrp_pkg::CHAR_BACKSLASH) begin
                  phase_in  = slrp_pkg::PH_FIRST;
                  offset_in = 4'd0;
               end
            end
            slrp_pkg::PH_FIRST, slrp_pkg::PH_NEXT: begin
               if (is_eot) begin
                  phase_in = slrp_pkg::PH_STOP;
                  cause_in = slrp_pkg::STOP_EOT;
               end else if (offset_ff == slrp_pkg::OFFSET_JUDGE) begin
                  // This byte is the ninth of the record: judge it now.
                  if (win_ff[slrp_pkg::SEP_POS] != slrp_pkg::CHAR_BACKSLASH) begin
                     phase_in = slrp_pkg::PH_STOP;
                     cause_in = slrp_pkg::STOP_SEP;
                  end else begin
                     pair.rec_valid = 1'b1;
                     count_in       = count_plus;
                     if (count_plus >= limit) begin
                        phase_in = slrp_pkg::PH_STOP;
                        cause_in = slrp_pkg::STOP_LIMIT;
                     end else begin
                        // The two bytes past the separator open the next record.
                        win_in[0] = win_ff[7];
                        win_in[1] = data_byte;
                        offset_in = slrp_pkg::OFFSET_CARRY;
                        phase_in  = slrp_pkg::PH_NEXT;
                     end
                  end
               end else begin
                  win_in[offset_ff[2:0]] = data_byte;
                  offset_in = offset_ff + 4'd1;
               end
            end
            default: begin
            end
         endcase

         if (packet_end) begin
            pair.sum_valid        = 1'b1;
            pair.sum.kind         = slrp_pkg::KIND_SUMMARY;
            pair.sum.record_count = count_in;
            pair.sum.stop_reason  = (phase_in == slrp_pkg::PH_STOP) ? cause_in
                                                                     : slrp_pkg::STOP_DATA;
            pair.sum.last         = 1'b1;
            phase_in  = slrp_pkg::PH_SEEK;
            offset_in = 4'd0;
            count_in  = 9'd0;
            cause_in  = slrp_pkg::STOP_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= slrp_pkg::PH_SEEK;
         cause_ff       <= slrp_pkg::STOP_DATA;
         offset_ff      <= 4'd0;
         count_ff       <= 9'd0;
         max_records_ff <= slrp_pkg::LIMIT_RESET;
      end else begin
         phase_ff  <= phase_in;
         cause_ff  <= cause_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
         if (csr_write) begin
            max_records_ff <= csr_data;
         end
      end
   end

   // Window bytes are always written before they are read within a packet.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

/* hdl/slrp_queue.sv */
`default_nettype none

module slrp_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  wire slrp_pkg::result_pair_type pair,
   output logic                      full,
   output logic                      out_valid,
   input  wire                       out_stall,
   output slrp_pkg::result_type      out_data
);

   slrp_pkg::result_type        q_ff [slrp_pkg::QUEUE_DEPTH];
   slrp_pkg::result_type        q_in [slrp_pkg::QUEUE_DEPTH];
   logic [slrp_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic [slrp_pkg::QUEUE_CW-1:0] base;
   logic [slrp_pkg::QUEUE_CW-1:0] n_push;
   slrp_pkg::result_type        first, second;
   logic                        pop;

   // Room for two results is needed before a byte is taken.
   assign full      = count_ff > slrp_pkg::QUEUE_CW'(slrp_pkg::QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = q_ff[0];
   assign pop       = out_valid && !out_stall;
   assign base      = count_ff - slrp_pkg::QUEUE_CW'(pop);
   assign first     = pair.rec_valid ? pair.rec : pair.sum;
   assign second    = pair.sum;
   assign n_push    = push ? (slrp_pkg::QUEUE_CW'(pair.rec_valid) +
                              slrp_pkg::QUEUE_CW'(pair.sum_valid)) : '0;
   assign count_in  = base + n_push;

   always_comb begin
      for (int i = 0; i < slrp_pkg::QUEUE_DEPTH; i++) begin
         if (pop && i < slrp_pkg::QUEUE_DEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (n_push != '0 && base == slrp_pkg::QUEUE_CW'(i)) begin
            q_in[i] = first;
         end
         if (n_push == slrp_pkg::QUEUE_CW'(2) &&
             base + slrp_pkg::QUEUE_CW'(1) == slrp_pkg::QUEUE_CW'(i)) begin
            q_in[i] = second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

`default_nettype wire

/* hdl/server_list_record_parser.sv */
`default_nettype none

// Server-list reply parser. Takes one payload byte per cycle while req_stall
// is low and returns address records (kind 0) and, on the byte marked
// packet_end, a summary (kind 1) with the record count and stop reason. Each
// byte is handled in the cycle it is accepted; its results enter a four-beat
// result queue that drains one beat per cycle while rsp_stall is low. A byte
// causes two results when a record completes on the packet's final byte.
// req_stall rises while fewer than two queue slots are free.
// The max_records register is written through the csr channel, which is
// always ready, and should only be written while no packet is in flight.
module server_list_record_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_packet_end,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_kind,
   output logic [31:0] rsp_ip_address,
   output logic [15:0] rsp_port_number,
   output logic [7:0]  rsp_record_index,
   output logic [8:0]  rsp_record_count,
   output logic [1:0]  rsp_stop_reason,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [8:0]  csr_max_records
);

   slrp_pkg::result_pair_type pair;
   slrp_pkg::result_type      head;
   logic                      accept;
   logic                      full;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   slrp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .packet_end (req_packet_end),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_max_records),
      .pair       (pair)
   );

   slrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .pair      (pair),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_ip_address   = head.ip_address;
   assign rsp_port_number  = head.port_number;
   assign rsp_record_index = head.record_index;
   assign rsp_record_count = head.record_count;
   assign rsp_stop_reason  = head.stop_reason;
   assign rsp_last         = head.last;

endmodule

`default_nettype wire

/* hdl/slrp_checker.sv */
`default_nettype none

module slrp_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_kind,
   input wire [31:0] rsp_ip_address,
   input wire [15:0] rsp_port_number,
   input wire [7:0]  rsp_record_index,
   input wire [8:0]  rsp_record_count,
   input wire [1:0]  rsp_stop_reason,
   input wire        rsp_last
);

   // Nothing is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_ip_address) && $stable(rsp_port_number) &&
      $stable(rsp_record_index) && $stable(rsp_record_count) &&
      $stable(rsp_stop_reason) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_summary_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == slrp_pkg::KIND_SUMMARY |-> rsp_last &&
      rsp_ip_address == 32'd0 && rsp_port_number == 16'd0 &&
      rsp_record_index == 8'd0 && rsp_record_count <= 9'd256)
      else $error("malformed summary beat");

   a_record_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == slrp_pkg::KIND_RECORD |->
      rsp_record_count == 9'd0 && rsp_stop_reason == slrp_pkg::STOP_DATA)
      else $error("malformed record beat");

   // A record beat marked not last must be followed by its packet summary.
   a_record_then_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == slrp_pkg::KIND_RECORD && !rsp_last |=>
      rsp_valid && rsp_kind == slrp_pkg::KIND_SUMMARY)
      else $error("record on final byte not followed by summary");

endmodule

bind server_list_record_parser slrp_checker u_slrp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_ip_address   (rsp_ip_address),
   .rsp_port_number  (rsp_port_number),
   .rsp_record_index (rsp_record_index),
   .rsp_record_count (rsp_record_count),
   .rsp_stop_reason  (rsp_stop_reason),
   .rsp_last         (rsp_last)
);

`default_nettype wire
